// File: rtl/core/snsq_pkg.sv
// ============================================================================
// snsq_pkg
// Shared types, widths, register codes and the note period ROM of the
// square-wave note sequencer.
// ============================================================================
package snsq_pkg;

    // Ring buffer geometry
    localparam int BUF_DEPTH = 1024;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

    // Field and register widths
    localparam int NOTE_W      = 8;
    localparam int NOTE_COUNT  = 128;
    localparam int NOTE_IDX_W  = $clog2(NOTE_COUNT);
    localparam int PERIOD_W    = 17;
    localparam int INTERVAL_W  = 24;
    localparam int OFFSET_W    = 10;
    localparam int LIMIT_W     = 11;
    localparam int FILL_OUT_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int CMP_W       = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    // Register reset values
    localparam int INTERVAL_RESET = 31250;
    localparam int OFFSET_RESET   = 0;
    localparam int LIMIT_RESET    = 768;
    localparam int REST_LEN_RESET = (INTERVAL_RESET / 1000) * 1000;

    // Reciprocal of 1000 for whole-millisecond rounding of a 24-bit interval
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;
    localparam int MS_W        = INTERVAL_W + RECIP_W - RECIP_SHIFT;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 2'd2;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Player mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TONE = 2'd1,
        MODE_REST = 2'd2
    } t_mode;

    // Ring buffer control and status between the top level and the buffer
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [NOTE_W-1:0] data;
    } t_fifo_ctrl;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] fill_next;
        logic [NOTE_W-1:0] head;
    } t_fifo_status;

    // Periods in microseconds of notes 0 to 11; each higher octave halves them
    typedef logic [PERIOD_W-1:0] t_period_rom [NOTE_COUNT];

    localparam logic [PERIOD_W-1:0] LOW_OCTAVE_PERIOD [12] = '{
        17'd122312, 17'd115447, 17'd108967, 17'd102851,
        17'd97079,  17'd91630,  17'd86487,  17'd81633,
        17'd77051,  17'd72727,  17'd68645,  17'd64792
    };

    // Flooring the exact period then shifting equals flooring the halved period.
    function automatic t_period_rom build_period_rom();
        t_period_rom rom;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            rom[i] = PERIOD_W'(LOW_OCTAVE_PERIOD[i % 12] >> (i / 12));
        end
        return rom;
    endfunction

    localparam t_period_rom PERIOD_ROM = build_period_rom();

endpackage

// File: rtl/core/square_wave_note_sequencer_unit.sv
// ============================================================================
// square_wave_note_sequencer_unit
// Note byte buffer and one-bit square-wave player, one microsecond per tick.
// ============================================================================
// Usage. Each input item is either a push of a note byte into a 1024-byte
// ring buffer or a one-microsecond tick of the player. Every item yields
// exactly one result item: the piezo level, whether a push was stored, the
// buffer fill after the item and the player mode.
// The input channel (i_in_valid / o_in_stall) and the output channel
// (o_out_valid / i_out_stall) accept an item at a clock edge with valid high
// and stall low. The result of an accepted item is loaded into the output
// register, and a new item is taken in every cycle that the receiver does not
// stall, so throughput is one item per cycle. While the receiver stalls with a
// result waiting, o_in_stall is raised and the block holds result and state.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes interval_us,
// half_period_offset and fill_limit by index; it is always ready and should
// only be used while the block is idle.
// Synchronous reset empties the buffer, idles the player with the output low
// and loads the register defaults. No clearing pass is needed.
// ============================================================================
module square_wave_note_sequencer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [snsq_pkg::NOTE_W-1:0]         i_note_byte,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_piezo_high,
    output logic                                o_push_accepted,
    output logic [snsq_pkg::FILL_OUT_W-1:0]     o_buffer_fill,
    output logic [1:0]                          o_player_mode,
    // Configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [snsq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [snsq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import snsq_pkg::*;

    // Configuration registers
    logic [INTERVAL_W-1:0] r_interval;
    logic [OFFSET_W-1:0]   r_offset;
    logic [LIMIT_W-1:0]    r_limit;
    logic [INTERVAL_W-1:0] r_rest_len;

    // Player state
    t_mode                 r_mode;
    t_mode                 n_mode;
    logic [INTERVAL_W-1:0] r_budget;
    logic [INTERVAL_W-1:0] n_budget;
    logic [INTERVAL_W-1:0] r_phase;
    logic [INTERVAL_W-1:0] n_phase;
    logic [PERIOD_W-1:0]   r_half;
    logic [PERIOD_W-1:0]   n_half;
    logic [PERIOD_W-1:0]   r_full;
    logic [PERIOD_W-1:0]   n_full;
    logic                  r_level;
    logic                  n_level;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_piezo;
    logic                  r_out_acc;
    logic [FILL_OUT_W-1:0] r_out_fill;
    t_mode                 r_out_mode;

    logic                         w_accept;
    logic                         w_is_push;
    logic                         w_is_tick;
    logic                         w_room;
    logic                         w_pop;
    logic                         w_start_tone;
    logic                         w_start_rest;
    logic [NOTE_W-1:0]            w_head;
    logic [PERIOD_W-1:0]          w_rom_p;
    logic [PERIOD_W-1:0]          w_half;
    logic [INTERVAL_W-1:0]        w_phase_dec;
    logic                         w_level_out;
    logic                         w_acc;
    logic [INTERVAL_W+RECIP_W-1:0] w_ms_prod;
    logic [MS_W-1:0]              w_ms;
    logic [INTERVAL_W:0]          w_rest_len;
    t_fifo_ctrl                   w_fifo_ctrl;
    t_fifo_status                 w_fifo_st;

    // Handshakes
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Rest length: interval rounded down to whole milliseconds, computed on
    // the configuration write with a reciprocal multiply and 1000 = 1024-16-8.
    assign w_ms_prod  = (INTERVAL_W + RECIP_W)'(i_cfg_data[INTERVAL_W-1:0])
                      * (INTERVAL_W + RECIP_W)'(RECIP_1000);
    assign w_ms       = w_ms_prod[INTERVAL_W+RECIP_W-1:RECIP_SHIFT];
    assign w_rest_len = ((INTERVAL_W + 1)'(w_ms) << 10)
                      - ((INTERVAL_W + 1)'(w_ms) << 4)
                      - ((INTERVAL_W + 1)'(w_ms) << 3);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_W'(INTERVAL_RESET);
            r_offset   <= OFFSET_W'(OFFSET_RESET);
            r_limit    <= LIMIT_W'(LIMIT_RESET);
            r_rest_len <= INTERVAL_W'(REST_LEN_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INTERVAL: begin
                    r_interval <= i_cfg_data[INTERVAL_W-1:0];
                    r_rest_len <= w_rest_len[INTERVAL_W-1:0];
                end
                CFG_OFFSET: begin
                    r_offset <= i_cfg_data[OFFSET_W-1:0];
                end
                CFG_FILL_LIMIT: begin
                    r_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Request decode, buffer room and the byte that an idle tick would start
    assign w_is_push = w_accept && (i_req_type == REQ_PUSH);
    assign w_is_tick = w_accept && (i_req_type == REQ_TICK);
    assign w_room    = (CMP_W'(w_fifo_st.fill) < CMP_W'(r_limit))
                    && (w_fifo_st.fill < FILL_W'(BUF_DEPTH));
    assign w_pop     = w_is_tick && (r_mode == MODE_IDLE) && (w_fifo_st.fill != '0);
    assign w_head    = w_fifo_st.head;
    assign w_rom_p   = PERIOD_ROM[w_head[NOTE_IDX_W-1:0]];
    assign w_half    = PERIOD_W'(w_rom_p >> 1) + PERIOD_W'(r_offset);

    // A note starts only if its period fits the interval; other bytes rest
    // if the rounded interval is at least one millisecond.
    assign w_start_tone = w_pop && (w_head < NOTE_W'(NOTE_COUNT))
                       && (r_interval >= INTERVAL_W'(w_rom_p));
    assign w_start_rest = w_pop && (w_head >= NOTE_W'(NOTE_COUNT))
                       && (r_rest_len != '0);

    assign w_phase_dec = (r_phase != '0) ? r_phase - INTERVAL_W'(1) : '0;

    // Buffer control
    assign w_fifo_ctrl.push = w_is_push && w_room;
    assign w_fifo_ctrl.pop  = w_pop;
    assign w_fifo_ctrl.data = i_note_byte;

    snsq_note_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_fifo_ctrl),
        .o_status (w_fifo_st)
    );

    // Player next state
    always_comb begin
        n_mode   = r_mode;
        n_budget = r_budget;
        n_phase  = r_phase;
        n_half   = r_half;
        n_full   = r_full;
        n_level  = r_level;
        if (w_is_tick) begin
            if (r_mode == MODE_IDLE) begin
                n_level = 1'b0;
                if (w_start_tone) begin
                    // The first microsecond of the high half is this tick.
                    n_mode   = MODE_TONE;
                    n_full   = w_rom_p;
                    n_budget = r_interval - INTERVAL_W'(w_rom_p);
                    n_half   = w_half;
                    n_phase  = INTERVAL_W'(w_half) - INTERVAL_W'(1);
                    n_level  = 1'b1;
                end else if (w_start_rest) begin
                    n_mode  = MODE_REST;
                    n_phase = r_rest_len - INTERVAL_W'(1);
                end
            end else begin
                n_phase = w_phase_dec;
                if (w_phase_dec == '0) begin
                    if (r_mode == MODE_REST) begin
                        n_mode  = MODE_IDLE;
                        n_level = 1'b0;
                    end else if (r_level) begin
                        n_level = 1'b0;
                        n_phase = INTERVAL_W'(r_half);
                    end else if ((r_budget >= INTERVAL_W'(r_full)) && (r_full != '0)) begin
                        n_budget = r_budget - INTERVAL_W'(r_full);
                        n_level  = 1'b1;
                        n_phase  = INTERVAL_W'(r_half);
                    end else begin
                        n_mode  = MODE_IDLE;
                        n_level = 1'b0;
                    end
                end
            end
        end
    end

    // Result fields of the item
    always_comb begin
        w_acc       = w_is_push && w_room;
        w_level_out = r_level;
        if (w_is_tick) begin
            w_level_out = (r_mode == MODE_IDLE) ? w_start_tone : r_level;
        end
    end

    // Player state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_budget <= '0;
            r_phase  <= '0;
            r_half   <= '0;
            r_full   <= '0;
            r_level  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_budget <= n_budget;
            r_phase  <= n_phase;
            r_half   <= n_half;
            r_full   <= n_full;
            r_level  <= n_level;
        end
    end

    // Output register: loaded on each accepted item, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_out_piezo <= w_level_out;
            r_out_acc   <= w_acc;
            r_out_fill  <= FILL_OUT_W'(w_fifo_st.fill_next);
            r_out_mode  <= n_mode;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_piezo_high    = r_out_piezo;
    assign o_push_accepted = r_out_acc;
    assign o_buffer_fill   = r_out_fill;
    assign o_player_mode   = r_out_mode;

endmodule

// File: rtl/core/snsq_ram.sv
// ============================================================================
// snsq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module snsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/snsq_note_fifo.sv
// ============================================================================
// snsq_note_fifo
// Ring buffer of note bytes with a show-ahead head, so that the oldest byte
// is available in the cycle in which it is popped.
// ============================================================================
module snsq_note_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  snsq_pkg::t_fifo_ctrl   i_ctrl,
    output snsq_pkg::t_fifo_status o_status
);
    import snsq_pkg::*;

    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_wptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [FILL_W-1:0] n_fill;
    logic              r_byp_valid;
    logic [NOTE_W-1:0] r_byp_data;
    logic [NOTE_W-1:0] w_ram_q;

    // Pointer and fill count updates, wrapping at the buffer depth
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            n_wptr = (r_wptr == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            n_fill = r_fill + FILL_W'(1);
        end
        if (i_ctrl.pop) begin
            n_rptr = (r_rptr == PTR_W'(BUF_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    // The RAM always reads the next head address. A write to that same
    // address in this cycle is caught by the bypass register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= i_ctrl.push && (r_wptr == n_rptr);
        end
        r_byp_data <= i_ctrl.data;
    end

    snsq_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.push),
        .i_wr_addr (r_wptr),
        .i_wr_data (i_ctrl.data),
        .i_rd_addr (n_rptr),
        .o_rd_data (w_ram_q)
    );

    assign o_status.fill      = r_fill;
    assign o_status.fill_next = n_fill;
    assign o_status.head      = r_byp_valid ? r_byp_data : w_ram_q;

endmodule
